// ===== hdl/bsil_pkg.sv =====
// Shared types and codes for the bounded sorted insert list.
`default_nettype none
package bsil_pkg;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 5;
   localparam int CAP_W       = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DESCENDING = 1'b1;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

   // Request opcodes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_POP    = 1'b1;

   // Response status codes
   localparam int STATUS_W = 3;
   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EVICTED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_POPPED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // latch request and register per-cell compare flags
      logic commit;    // update cells and load the response register
   } dp_cmd_type;

endpackage
`default_nettype wire

// ===== hdl/bounded_sorted_insert_list_top.sv =====
// Top level: bounded sorted insert list with configuration registers.
// An accepted request item is captured with its compare flags; its result is
// registered at the later commit step, which waits while a response is unread.
// No new item is accepted until that commit (capture then commit in the controller).
// Reset: synchronous active high; empties the list, capacity 16, ascending order.
// Entry cells hold no reset value; only cells below the fill count are read.
`default_nettype none
module bounded_sorted_insert_list_top #(
   parameter int DEPTH         = 16,
   parameter int KEY_WIDTH     = 32,
   parameter int PAYLOAD_WIDTH = 16,
   localparam int CNT_W        = $clog2(DEPTH + 1)
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_opcode,
   input  wire logic [KEY_WIDTH-1:0]                req_key,
   input  wire logic [PAYLOAD_WIDTH-1:0]            req_payload,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [bsil_pkg::STATUS_W-1:0]            rsp_status,
   output logic [KEY_WIDTH-1:0]                     rsp_out_key,
   output logic [PAYLOAD_WIDTH-1:0]                 rsp_out_payload,
   output logic [CNT_W-1:0]                         rsp_fill,
   // configuration write channel
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [bsil_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [bsil_pkg::CSR_DATA_W-1:0]     csr_data
);
   import bsil_pkg::*;

   // configuration registers
   logic [CAP_W-1:0] capacity_ff;
   logic             descending_ff;
   dp_cmd_type       cmd;

   // writes are always taken; software must write only while the list is idle, the block does not enforce it
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= CAPACITY_RESET;
         descending_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CAPACITY:   capacity_ff   <= csr_data[CAP_W-1:0];
            CSR_DESCENDING: descending_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // controller: accept an item, then commit it into the response register
   bsil_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // datapath: entry cells, compare flags, insert/evict/pop update
   bsil_datapath #(
      .DEPTH         (DEPTH),
      .KEY_WIDTH     (KEY_WIDTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
      .CNT_W         (CNT_W)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .capacity        (capacity_ff),
      .descending      (descending_ff),
      .req_opcode      (req_opcode),
      .req_key         (req_key),
      .req_payload     (req_payload),
      .rsp_status      (rsp_status),
      .rsp_out_key     (rsp_out_key),
      .rsp_out_payload (rsp_out_payload),
      .rsp_fill        (rsp_fill)
   );

endmodule
`default_nettype wire

// ===== hdl/bsil_ctrl.sv =====
// Controller: sequences capture and commit and owns the response valid.
`default_nettype none
module bsil_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output bsil_pkg::dp_cmd_type    cmd
);
   import bsil_pkg::*;

   localparam logic S_IDLE   = 1'b0;
   localparam logic S_UPDATE = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_UPDATE;
            end
         end
         S_UPDATE: begin
            // hold until the response register can take the result
            if (slot_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/bsil_datapath.sv =====
// Datapath: row of sorted entry cells, compare flags and response register.
`default_nettype none
module bsil_datapath #(
   parameter int DEPTH         = 16,
   parameter int KEY_WIDTH     = 32,
   parameter int PAYLOAD_WIDTH = 16,
   parameter int CNT_W         = 5
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire bsil_pkg::dp_cmd_type           cmd,
   input  wire logic [bsil_pkg::CAP_W-1:0]     capacity,
   input  wire logic                           descending,
   input  wire logic                           req_opcode,
   input  wire logic [KEY_WIDTH-1:0]           req_key,
   input  wire logic [PAYLOAD_WIDTH-1:0]       req_payload,
   output logic [bsil_pkg::STATUS_W-1:0]       rsp_status,
   output logic [KEY_WIDTH-1:0]                rsp_out_key,
   output logic [PAYLOAD_WIDTH-1:0]            rsp_out_payload,
   output logic [CNT_W-1:0]                    rsp_fill
);
   import bsil_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // entry cells
   logic [KEY_WIDTH-1:0]     key_ff [DEPTH];
   logic [KEY_WIDTH-1:0]     key_in [DEPTH];
   logic [PAYLOAD_WIDTH-1:0] pay_ff [DEPTH];
   logic [PAYLOAD_WIDTH-1:0] pay_in [DEPTH];
   logic [CNT_W-1:0]         count_ff, count_in;

   // captured request and per-cell flags
   logic                     op_ff;
   logic [KEY_WIDTH-1:0]     new_key_ff;
   logic [PAYLOAD_WIDTH-1:0] new_pay_ff;
   logic [DEPTH-1:0]         hit_ff, hit_in;
   logic [DEPTH-1:0]         beyond_ff, beyond_in;
   logic                     full_ff, full_in;

   // response register
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic [KEY_WIDTH-1:0]     out_key_ff, out_key_in;
   logic [PAYLOAD_WIDTH-1:0] out_pay_ff, out_pay_in;
   logic [CNT_W-1:0]         fill_ff;

   logic [CNT_W-1:0]         cap_eff;
   logic [CNT_W-1:0]         limit;
   logic [CNT_W-1:0]         count_m1;
   logic [DEPTH-1:0]         shift_from;
   logic                     found;
   logic                     reject;

   // clamp capacity into one to DEPTH
   always_comb begin
      priority if (32'(capacity) > 32'(DEPTH)) begin
         cap_eff = CNT_W'(DEPTH);
      end else if (capacity == '0) begin
         cap_eff = CNT_W'(1);
      end else begin
         cap_eff = CNT_W'(capacity);
      end
      full_in = (count_ff >= cap_eff);
      limit   = full_in ? cap_eff : count_ff;
   end

   // per-cell compare against the incoming key
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         beyond_in[i] = (CNT_W'(i) >= limit);
         hit_in[i]    = !beyond_in[i] &&
                        (descending ? (req_key >= key_ff[i]) : (req_key <= key_ff[i]));
      end
   end

   // first hit and everything after it (or past the search limit) shifts down
   always_comb begin
      logic run;
      run = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         run           = run | hit_ff[i] | beyond_ff[i];
         shift_from[i] = run;
      end
   end

   assign found    = |hit_ff;
   assign reject   = full_ff && !found;
   assign count_m1 = count_ff - CNT_W'(1);

   always_comb begin
      count_in   = count_ff;
      status_in  = ST_INSERTED;
      out_key_in = '0;
      out_pay_in = '0;
      for (int i = 0; i < DEPTH; i++) begin
         key_in[i] = key_ff[i];
         pay_in[i] = pay_ff[i];
      end
      if (op_ff == OP_POP) begin
         if (count_ff == '0) begin
            status_in = ST_EMPTY;
         end else begin
            status_in  = ST_POPPED;
            out_key_in = key_ff[0];
            out_pay_in = pay_ff[0];
            count_in   = count_m1;
            for (int i = 0; i < DEPTH - 1; i++) begin
               key_in[i] = key_ff[i+1];
               pay_in[i] = pay_ff[i+1];
            end
         end
      end else if (reject) begin
         status_in  = ST_REJECTED;
         out_key_in = new_key_ff;
         out_pay_in = new_pay_ff;
      end else begin
         if (full_ff) begin
            status_in  = ST_EVICTED;
            out_key_in = key_ff[count_m1[IDX_W-1:0]];
            out_pay_in = pay_ff[count_m1[IDX_W-1:0]];
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
         for (int i = 0; i < DEPTH; i++) begin
            if (i > 0 && shift_from[(i > 0) ? i - 1 : 0]) begin
               key_in[i] = key_ff[(i > 0) ? i - 1 : 0];
               pay_in[i] = pay_ff[(i > 0) ? i - 1 : 0];
            end else if (shift_from[i]) begin
               key_in[i] = new_key_ff;
               pay_in[i] = new_pay_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_opcode;
         new_key_ff <= req_key;
         new_pay_ff <= req_payload;
         hit_ff     <= hit_in;
         beyond_ff  <= beyond_in;
         full_ff    <= full_in;
      end
      if (cmd.commit) begin
         for (int i = 0; i < DEPTH; i++) begin
            key_ff[i] <= key_in[i];
            pay_ff[i] <= pay_in[i];
         end
         status_ff  <= status_in;
         out_key_ff <= out_key_in;
         out_pay_ff <= out_pay_in;
         fill_ff    <= count_in;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_out_key     = out_key_ff;
   assign rsp_out_payload = out_pay_ff;
   assign rsp_fill        = fill_ff;

endmodule
`default_nettype wire
